// ----- src/cti_pkg.sv -----
package cti_pkg;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int TEMP_W   = 16;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = SAMPLE_W + TEMP_W;

    // Minimum number of table entries in use
    localparam int MIN_ENTRIES = 4;

    // Magnitude of (sample offset) * (temperature difference) fits in 28 bits
    localparam int DIV_W   = 28;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_CONVERT = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INTERP    = 2'd0,
        ST_CLAMP_LO  = 2'd1,
        ST_CLAMP_HI  = 2'd2,
        ST_NO_SEG    = 2'd3
    } status_t;

    typedef struct packed {
        logic                start;
        logic [DIV_W-1:0]    dividend;
        logic [SAMPLE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- src/cti_if.sv -----
interface cti_req_if import cti_pkg::*;;
    logic                valid;
    logic                ready;
    logic                opcode;
    logic [INDEX_W-1:0]  entry_index;
    logic [SAMPLE_W-1:0] point_sample;
    logic [TEMP_W-1:0]   point_temperature;
    logic [SAMPLE_W-1:0] adc_sample;

    modport source (
        output valid, opcode, entry_index, point_sample, point_temperature, adc_sample,
        input  ready
    );
    modport sink (
        input  valid, opcode, entry_index, point_sample, point_temperature, adc_sample,
        output ready
    );
endinterface

interface cti_res_if import cti_pkg::*;;
    logic                valid;
    logic                ready;
    logic [TEMP_W-1:0]   temperature;
    logic [STATUS_W-1:0] status;

    modport source (output valid, temperature, status, input ready);
    modport sink (input valid, temperature, status, output ready);
endinterface

interface cti_cfg_if import cti_pkg::*;;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- src/cti_ram.sv -----
module cti_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- src/cti_div.sv -----
module cti_div import cti_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic [SAMPLE_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [SAMPLE_W-1:0]  divisor_reg, divisor_next;
    logic [SAMPLE_W:0]    trial;
    logic [SAMPLE_W:0]    diff;
    logic                 fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            count_next   = DIV_CNT_W'(DIV_W - 1);
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        count_reg   <= count_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- src/calibration_table_interpolator.sv -----
// Channel   Modport  Moves
// request   sink     load items (entry write) and convert items (sample)
// result    source   temperature and status, one per convert item
// cfg       sink     number of table entries in use
//
// A load writes the table memory at the transfer.
// A convert reads the table memory one entry per cycle: a high clamp reads
// entries N-2 and N-1 (N entries in use), a low clamp N-2, 1 and 0, and an
// interpolation N-2, 1 and then each segment end up to the bracketing one,
// then multiplies and divides with the restoring divider.
// Reset clears control state only; table entries are undefined until loaded.
// A held result blocks only the next result, not the next transfer in.
module calibration_table_interpolator import cti_pkg::*; #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    cti_req_if.sink    request,
    cti_res_if.source  result,
    cti_cfg_if.sink    cfg
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int NW = $clog2(TABLE_ENTRIES + 1);
    localparam int CW = ((NW > COUNT_W) ? NW : COUNT_W) + 1;
    localparam int PW = SAMPLE_W + TEMP_W + 2;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_RD_HI   = 10'b00_0000_0010,
        S_RD_LAST = 10'b00_0000_0100,
        S_RD_ONE  = 10'b00_0000_1000,
        S_RD_ZERO = 10'b00_0001_0000,
        S_SCAN    = 10'b00_0010_0000,
        S_MUL     = 10'b00_0100_0000,
        S_DSTART  = 10'b00_1000_0000,
        S_DWAIT   = 10'b01_0000_0000,
        S_FIN     = 10'b10_0000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [COUNT_W-1:0]    entries_in_use_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [TEMP_W-1:0]     out_temp_reg;
    logic [STATUS_W-1:0]   out_status_reg;

    logic [SAMPLE_W-1:0]   x_reg, x_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [SAMPLE_W-1:0]   lo_reg, lo_next;
    logic [TEMP_W-1:0]     t0_reg, t0_next;
    logic [SAMPLE_W-1:0]   xoff_reg, xoff_next;
    logic [SAMPLE_W-1:0]   dx_reg, dx_next;
    logic signed [TEMP_W:0] tdiff_reg, tdiff_next;
    logic signed [PW-1:0]  prod_reg, prod_next;
    logic [TEMP_W-1:0]     res_temp_reg, res_temp_next;
    status_t               res_status_reg, res_status_next;

    logic [CW-1:0]         eiu_ext;
    logic [CW-1:0]         n_val;
    logic                  take;
    logic                  load_we;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [ENTRY_W-1:0]    rd_data;
    logic [SAMPLE_W-1:0]   rd_sample;
    logic [TEMP_W-1:0]     rd_temp;
    logic [DIV_W-1:0]      prod_mag;
    logic [TEMP_W-1:0]     q_low;
    div_req_t              div_req;
    div_rsp_t              div_rsp;

    // Clamp the entry count to the range MIN_ENTRIES to the table size
    assign eiu_ext = CW'(entries_in_use_reg);
    always_comb
    begin
        if (eiu_ext < CW'(MIN_ENTRIES))
        begin
            n_val = CW'(MIN_ENTRIES);
        end
        else if (eiu_ext > CW'(TABLE_ENTRIES))
        begin
            n_val = CW'(TABLE_ENTRIES);
        end
        else
        begin
            n_val = eiu_ext;
        end
    end

    assign request.ready = (state_reg == S_IDLE);
    assign take          = request.valid && request.ready;
    assign load_we       = take && (request.opcode == OP_LOAD)
                           && (CW'(request.entry_index) < CW'(TABLE_ENTRIES));

    assign cfg.ready = 1'b1;

    assign rd_sample = rd_data[ENTRY_W-1:TEMP_W];
    assign rd_temp   = rd_data[TEMP_W-1:0];

    // Table memory: sample point in the upper bits, temperature below
    cti_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (load_we),
        .wr_addr (AW'(request.entry_index)),
        .wr_data ({request.point_sample, request.point_temperature}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Divider for the segment interpolation
    assign prod_mag         = prod_reg[PW-1] ? DIV_W'(-prod_reg) : DIV_W'(prod_reg);
    assign div_req.start    = (state_reg == S_DSTART);
    assign div_req.dividend = prod_mag;
    assign div_req.divisor  = dx_reg;

    cti_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign q_low = div_rsp.quotient[TEMP_W-1:0];

    // Sequence the table reads, scan and interpolation
    always_comb
    begin
        state_next      = state_reg;
        x_next          = x_reg;
        idx_next        = idx_reg;
        lo_next         = lo_reg;
        t0_next         = t0_reg;
        xoff_next       = xoff_reg;
        dx_next         = dx_reg;
        tdiff_next      = tdiff_reg;
        prod_next       = prod_reg;
        res_temp_next   = res_temp_reg;
        res_status_next = res_status_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        out_valid_next  = out_valid_reg && !result.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (take && (request.opcode == OP_CONVERT))
                begin
                    x_next     = request.adc_sample;
                    rd_en      = 1'b1;
                    rd_addr    = AW'(n_val - CW'(2));
                    state_next = S_RD_HI;
                end
            end
            S_RD_HI:
            begin
                rd_en = 1'b1;
                if (x_reg > rd_sample)
                begin
                    rd_addr    = AW'(n_val - CW'(1));
                    state_next = S_RD_LAST;
                end
                else
                begin
                    rd_addr    = AW'(1);
                    state_next = S_RD_ONE;
                end
            end
            S_RD_LAST:
            begin
                res_temp_next   = rd_temp;
                res_status_next = ST_CLAMP_HI;
                state_next      = S_FIN;
            end
            S_RD_ONE:
            begin
                rd_en = 1'b1;
                if (x_reg < rd_sample)
                begin
                    rd_addr    = '0;
                    state_next = S_RD_ZERO;
                end
                else
                begin
                    lo_next    = rd_sample;
                    t0_next    = rd_temp;
                    idx_next   = AW'(1);
                    rd_addr    = AW'(2);
                    state_next = S_SCAN;
                end
            end
            S_RD_ZERO:
            begin
                res_temp_next   = rd_temp;
                res_status_next = ST_CLAMP_LO;
                state_next      = S_FIN;
            end
            S_SCAN:
            begin
                if ((x_reg >= lo_reg) && (x_reg <= rd_sample))
                begin
                    // Bracketing segment found
                    dx_next    = rd_sample - lo_reg;
                    xoff_next  = x_reg - lo_reg;
                    tdiff_next = $signed({1'b0, rd_temp}) - $signed({1'b0, t0_reg});
                    if (rd_sample == lo_reg)
                    begin
                        res_temp_next   = t0_reg;
                        res_status_next = ST_INTERP;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
                else if ((CW'(idx_reg) + CW'(4)) > n_val)
                begin
                    res_temp_next   = '0;
                    res_status_next = ST_NO_SEG;
                    state_next      = S_FIN;
                end
                else
                begin
                    // Advance to the next segment
                    lo_next  = rd_sample;
                    t0_next  = rd_temp;
                    idx_next = idx_reg + 1'b1;
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + AW'(2);
                end
            end
            S_MUL:
            begin
                // Widen both operands to the product width before multiplying
                prod_next  = $signed({{(PW-SAMPLE_W){1'b0}}, xoff_reg})
                             * $signed({{(PW-TEMP_W-1){tdiff_reg[TEMP_W]}}, tdiff_reg});
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_rsp.done)
                begin
                    res_temp_next   = (prod_reg[PW-1] ? (-q_low) : q_low) + t0_reg;
                    res_status_next = ST_INTERP;
                    state_next      = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            out_valid_reg      <= 1'b0;
            entries_in_use_reg <= COUNT_W'(64);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                entries_in_use_reg <= cfg.data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        idx_reg        <= idx_next;
        lo_reg         <= lo_next;
        t0_reg         <= t0_next;
        xoff_reg       <= xoff_next;
        dx_reg         <= dx_next;
        tdiff_reg      <= tdiff_next;
        prod_reg       <= prod_next;
        res_temp_reg   <= res_temp_next;
        res_status_reg <= res_status_next;
        if ((state_reg == S_FIN) && (!out_valid_reg || result.ready))
        begin
            out_temp_reg   <= res_temp_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.temperature = out_temp_reg;
    assign result.status      = out_status_reg;

endmodule

// ----- test/tb.sv -----
module tb;
    import cti_pkg::*;

    localparam int TABLE_DEPTH    = 64;
    localparam int SETTLE_CYCLES  = 150;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int QUIET_LIMIT    = 4000;
    localparam int NUM_PHASES     = 9;
    localparam int MIXED_ITEMS    = 62;
    localparam int NUM_DIRECTED   = 21;

    typedef struct {
        logic [TEMP_W-1:0] temperature;
        status_t           status;
    } conversion_t;

    typedef struct {
        opcode_t             op;
        logic [INDEX_W-1:0]  index;
        logic [SAMPLE_W-1:0] point_sample;
        logic [TEMP_W-1:0]   point_temperature;
        logic [SAMPLE_W-1:0] adc_sample;
        bit                  typed;
        logic [TEMP_W-1:0]   temperature;
        status_t             status;
    } directed_row_t;

    logic clk;
    logic rst_n;

    cti_req_if request_ch ();
    cti_res_if result_ch ();
    cti_cfg_if cfg_ch ();

    calibration_table_interpolator #(
        .TABLE_ENTRIES(TABLE_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .request(request_ch),
        .result(result_ch),
        .cfg(cfg_ch)
    );

    // Shadow copy of the calibration table and the entry count register
    logic [SAMPLE_W-1:0] cal_sample [TABLE_DEPTH];
    logic [TEMP_W-1:0]   cal_temp [TABLE_DEPTH];
    logic [COUNT_W-1:0]  entry_count_reg;

    conversion_t pending_conversions [$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_off_request;

    // Table with four entries: clamps, segment ends, falling slope, zero-width segment
    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{OP_LOAD,    6'd0,  12'd4095, 16'h1234, 12'd0,    1'b0, 16'd0,     ST_INTERP},
        '{OP_LOAD,    6'd1,  12'd16,   16'd1000, 12'd4095, 1'b0, 16'd0,     ST_INTERP},
        '{OP_LOAD,    6'd2,  12'd4000, 16'hFFFF, 12'd0,    1'b0, 16'd0,     ST_INTERP},
        '{OP_LOAD,    6'd3,  12'd0,    16'h0F0F, 12'd0,    1'b0, 16'd0,     ST_INTERP},
        '{OP_CONVERT, 6'd0,  12'd0,    16'd0,    12'd0,    1'b1, 16'h1234,  ST_CLAMP_LO},
        '{OP_CONVERT, 6'd0,  12'd0,    16'd0,    12'd15,   1'b1, 16'h1234,  ST_CLAMP_LO},
        '{OP_CONVERT, 6'd0,  12'd0,    16'd0,    12'd4095, 1'b1, 16'h0F0F,  ST_CLAMP_HI},
        '{OP_CONVERT, 6'd0,  12'd0,    16'd0,    12'd4001, 1'b1, 16'h0F0F,  ST_CLAMP_HI},
        '{OP_CONVERT, 6'd0,  12'd0,    16'd0,    12'd16,   1'b1, 16'd1000,  ST_INTERP},
        '{OP_CONVERT, 6'd0,  12'd0,    16'd0,    12'd4000, 1'b1, 16'hFFFF,  ST_INTERP},
        '{OP_CONVERT, 6'd0,  12'd0,    16'd0,    12'd2008, 1'b0, 16'd0,     ST_INTERP},
        '{OP_CONVERT, 6'd0,  12'd0,    16'd0,    12'd2047, 1'b0, 16'd0,     ST_INTERP},
        '{OP_LOAD,    6'd1,  12'd16,   16'hFFFF, 12'd0,    1'b0, 16'd0,     ST_INTERP},
        '{OP_LOAD,    6'd2,  12'd4000, 16'd0,    12'd0,    1'b0, 16'd0,     ST_INTERP},
        '{OP_CONVERT, 6'd0,  12'd0,    16'd0,    12'd17,   1'b0, 16'd0,     ST_INTERP},
        '{OP_CONVERT, 6'd0,  12'd0,    16'd0,    12'd3999, 1'b0, 16'd0,     ST_INTERP},
        '{OP_LOAD,    6'd63, 12'd4095, 16'hFFFF, 12'd0,    1'b0, 16'd0,     ST_INTERP},
        '{OP_LOAD,    6'd2,  12'd16,   16'd7,    12'd0,    1'b0, 16'd0,     ST_INTERP},
        '{OP_CONVERT, 6'd0,  12'd0,    16'd0,    12'd16,   1'b1, 16'hFFFF,  ST_INTERP},
        '{OP_CONVERT, 6'd0,  12'd0,    16'd0,    12'd17,   1'b1, 16'h0F0F,  ST_CLAMP_HI},
        '{OP_CONVERT, 6'd0,  12'd0,    16'd0,    12'd2048, 1'b1, 16'h0F0F,  ST_CLAMP_HI}
    };

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Entry count saturated to the legal range
    function automatic int unsigned entries_active();
        int unsigned n;
        n = entry_count_reg;
        if (n < MIN_ENTRIES)
            n = MIN_ENTRIES;
        if (n > TABLE_DEPTH)
            n = TABLE_DEPTH;
        return n;
    endfunction

    // Clamp, interpolate within the first bracketing segment, or report no segment
    function automatic conversion_t predict_conversion(input logic [SAMPLE_W-1:0] x);
        int unsigned     n;
        longint          t0;
        longint          t1;
        longint          dx;
        longint          r;
        conversion_t     res;
        n = entries_active();
        if (x > cal_sample[n-2]) begin
            res.temperature = cal_temp[n-1];
            res.status = ST_CLAMP_HI;
            return res;
        end
        if (x < cal_sample[1]) begin
            res.temperature = cal_temp[0];
            res.status = ST_CLAMP_LO;
            return res;
        end
        for (int i = 1; i + 1 <= n - 2; i++) begin
            if (x >= cal_sample[i] && x <= cal_sample[i+1]) begin
                t0 = longint'(cal_temp[i]);
                t1 = longint'(cal_temp[i+1]);
                dx = longint'(cal_sample[i+1]) - longint'(cal_sample[i]);
                r = t0;
                // Signed product, division truncating toward zero
                if (dx != 0)
                    r = (longint'(x) - longint'(cal_sample[i])) * (t1 - t0) / dx + t0;
                res.temperature = TEMP_W'(r);
                res.status = ST_INTERP;
                return res;
            end
        end
        res.temperature = '0;
        res.status = ST_NO_SEG;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Offer one item, wait for its transfer, then update the shadow table or queue the result
    task automatic send_item(
        input opcode_t             op,
        input logic [INDEX_W-1:0]  index,
        input logic [SAMPLE_W-1:0] point_sample,
        input logic [TEMP_W-1:0]   point_temperature,
        input logic [SAMPLE_W-1:0] adc_sample,
        input bit                  typed,
        input conversion_t         typed_result
    );
        while ($urandom_range(99) < send_idle_pct) begin
            request_ch.valid <= 1'b0;
            @(posedge clk);
        end
        request_ch.valid             <= 1'b1;
        request_ch.opcode            <= op;
        request_ch.entry_index       <= index;
        request_ch.point_sample      <= point_sample;
        request_ch.point_temperature <= point_temperature;
        request_ch.adc_sample        <= adc_sample;
        do
            @(posedge clk);
        while (request_ch.ready !== 1'b1);
        if (op == OP_LOAD) begin
            cal_sample[index] = point_sample;
            cal_temp[index]   = point_temperature;
        end
        else if (typed)
            pending_conversions.push_back(typed_result);
        else
            pending_conversions.push_back(predict_conversion(adc_sample));
    endtask

    // Write the entry count once the block has drained
    task automatic write_entry_count(input logic [COUNT_W-1:0] value);
        request_ch.valid <= 1'b0;
        while (pending_conversions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        entry_count_reg = value;
    endtask

    // Load every entry in use with ascending points, then mix conversions with reloads
    task automatic run_phase(input logic [COUNT_W-1:0] count_value, input bit pressure);
        int unsigned         n;
        logic [SAMPLE_W-1:0] points [$];
        int                  order [$];
        logic [SAMPLE_W-1:0] x;
        logic [INDEX_W-1:0]  index;
        conversion_t         unused;
        unused.temperature = '0;
        unused.status = ST_INTERP;
        write_entry_count(count_value);
        n = entries_active();
        for (int k = 0; k < n; k++) begin
            if (k > 0 && $urandom_range(5) == 0)
                points.push_back(points[k-1]);
            else
                points.push_back($urandom_range(4095));
            order.push_back(k);
        end
        points.sort();
        order.shuffle();
        foreach (order[k])
            send_item(OP_LOAD, INDEX_W'(order[k]), points[order[k]], $urandom_range(65535),
                      $urandom_range(4095), 1'b0, unused);
        if (pressure)
            hold_off_request = 1'b1;
        for (int j = 0; j < MIXED_ITEMS; j++) begin
            if ($urandom_range(3) != 0) begin
                case ($urandom_range(7))
                    0: x = $urandom_range(4095);
                    1: x = cal_sample[$urandom_range(n - 2, 1)];
                    2: x = $urandom_range(1) ? 12'd0 : 12'd4095;
                    3: x = (cal_sample[1] > 0) ? $urandom_range(cal_sample[1] - 1, 0)
                                               : $urandom_range(4095);
                    4: x = (cal_sample[n-2] < 4095) ? $urandom_range(4095, cal_sample[n-2] + 1)
                                                    : $urandom_range(4095);
                    default: x = $urandom_range(cal_sample[1], cal_sample[n-2]);
                endcase
                send_item(OP_CONVERT, $urandom_range(63), $urandom_range(4095),
                          $urandom_range(65535), x, 1'b0, unused);
            end
            else if ($urandom_range(1) == 0) begin
                // Retune a temperature and keep the sample points ascending
                index = $urandom_range(n - 1);
                send_item(OP_LOAD, index, cal_sample[index], $urandom_range(65535),
                          $urandom_range(4095), 1'b0, unused);
            end
            else
                send_item(OP_LOAD, $urandom_range(63), $urandom_range(4095),
                          $urandom_range(65535), $urandom_range(4095), 1'b0, unused);
        end
    endtask

    // Result side: check each transfer, then pick the next ready
    initial
    begin
        int          hold_left;
        conversion_t want;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
                if (pending_conversions.size() == 0)
                    report_mismatch($sformatf("unexpected result temperature %0d status %0d",
                                              result_ch.temperature, result_ch.status));
                else begin
                    want = pending_conversions.pop_front();
                    if (result_ch.temperature !== want.temperature)
                        report_mismatch($sformatf("temperature %0d, want %0d",
                                                  result_ch.temperature, want.temperature));
                    if (result_ch.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %s",
                                                  result_ch.status, want.status.name()));
                end
            end
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run after a long stretch with no transfer
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge clk);
            if ((request_ch.valid === 1'b1 && request_ch.ready === 1'b1) ||
                (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) ||
                (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("calibration_table_interpolator verification failed");
        $finish;
    end

    // Main sequence
    initial
    begin
        logic [COUNT_W-1:0] phase_counts [NUM_PHASES];
        conversion_t        row_result;
        phase_counts = '{7'd0, 7'd127, 7'd5, 7'd20, 7'd64, 7'd3, 7'd65, 7'd40, 7'd4};
        mismatches       = 0;
        hold_off_request = 1'b0;
        entry_count_reg  = 7'd64;
        send_idle_pct    = 27;
        recv_idle_pct    = 54;
        rst_n                        <= 1'b0;
        request_ch.valid             <= 1'b0;
        request_ch.opcode            <= OP_LOAD;
        request_ch.entry_index       <= '0;
        request_ch.point_sample      <= '0;
        request_ch.point_temperature <= '0;
        request_ch.adc_sample        <= '0;
        cfg_ch.valid                 <= 1'b0;
        cfg_ch.data                  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows on a four-entry table (count below range saturates up)
        write_entry_count(7'd2);
        foreach (directed_rows[r]) begin
            row_result.temperature = directed_rows[r].temperature;
            row_result.status      = directed_rows[r].status;
            send_item(directed_rows[r].op, directed_rows[r].index,
                      directed_rows[r].point_sample, directed_rows[r].point_temperature,
                      directed_rows[r].adc_sample, directed_rows[r].typed, row_result);
        end

        // Random phases: sender-light, receiver-light, then no idling
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 3) begin
                send_idle_pct = 27;
                recv_idle_pct = 54;
            end
            else if (p < 6) begin
                send_idle_pct = 54;
                recv_idle_pct = 27;
            end
            else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_phase(phase_counts[p], p == 1);
        end

        // Drain
        request_ch.valid <= 1'b0;
        while (pending_conversions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("calibration_table_interpolator verification clean");
        else
            $display("calibration_table_interpolator verification failed");
        $finish;
    end

endmodule
